// File: sv/lpqsd_pkg.sv
package lpqsd_pkg;

  // Field widths fixed by the interface
  localparam int ADDR_W     = 9;
  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 4;
  localparam int TICKS_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Four serial data lines, one memory bank each
  localparam int LINES = 4;

  // Default geometry
  localparam int ROW_SELECTS_DEF     = 4;
  localparam int ROWS_PER_LINE_DEF   = 16;
  localparam int MAX_WIDTH_BYTES_DEF = 8;

  // Register reset values
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 4'd8;
  localparam logic [TICKS_W-1:0] ON_RST    = 16'd2;
  localparam logic [TICKS_W-1:0] OFF_RST   = 16'd3;

  // Blank pixel byte (all dark)
  localparam logic [PIX_W-1:0] PIX_BLANK = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS   = 2'd2;

  // Request modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Scan sequencer phases
  typedef enum logic [2:0] {
    PH_SHIFT_LOW  = 3'd0,
    PH_SHIFT_HIGH = 3'd1,
    PH_ROW_SEL    = 3'd2,
    PH_LATCH_LOW  = 3'd3,
    PH_LATCH_HIGH = 3'd4,
    PH_ON         = 3'd5,
    PH_OFF        = 3'd6
  } phase_e;

  // Control pin levels (everything but the data lines)
  typedef struct packed {
    logic clk;
    logic row_a;
    logic row_b;
    logic stb;
    logic en;
  } pins_t;

  // Request in flight between memory read and result register
  typedef struct packed {
    pins_t      pins;
    logic       load;
    logic [2:0] bit_sel;
  } stage_t;

endpackage

// File: sv/lpqsd_ram.sv
module lpqsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/led_panel_quarter_scan_driver_top.sv
// Quarter-scan driver for a one-colour LED matrix panel with folded data lines.
// Input channel (in_valid_i/in_ready_o) carries requests: mode 0 writes one
// pixel byte into the frame store at address_i, mode 1 advances the pin
// sequencer by one tick. Every request gives exactly one result on the output
// channel (out_valid_o/out_ready_i): the panel pin levels after that request.
// out_valid_o rises after the request has passed the read stage and then the
// result register; one request is taken per cycle in steady state while
// out_ready_i holds no stall. The rate is set by the frame store: four banks
// (one per data line) with one write and one registered read per cycle each,
// read together on a shift-low tick and written one at a time by a write.
// A receiver stall fills the result register and then the read stage, after
// which in_ready_o drops; nothing is lost or repeated.
// After reset the frame store is swept to blank (0xFF) over all
// ROWS_PER_LINE * MAX_WIDTH_BYTES bank addresses (128 at the defaults) with
// in_ready_o low; configuration writes are taken throughout. Reset also sets
// the sequencer to shift-low of scan row 0, all pins low but the latch
// strobe, width 8 bytes, 2 on ticks and 3 off ticks.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 width_bytes, 1 on_ticks, 2 off_ticks); other indexes are ignored.
module led_panel_quarter_scan_driver_top
  import lpqsd_pkg::*;
#(
  parameter int ROW_SELECTS     = ROW_SELECTS_DEF,
  parameter int ROWS_PER_LINE   = ROWS_PER_LINE_DEF,
  parameter int MAX_WIDTH_BYTES = MAX_WIDTH_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [ADDR_W-1:0]     address_i,
  input  logic [PIX_W-1:0]      pixel_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  shift_clock_o,
  output logic                  line_one_o,
  output logic                  line_two_o,
  output logic                  line_three_o,
  output logic                  line_four_o,
  output logic                  row_sel_a_o,
  output logic                  row_sel_b_o,
  output logic                  latch_strobe_o,
  output logic                  output_enable_o
);

  localparam int FOLD_GROUPS = ROWS_PER_LINE / ROW_SELECTS;
  localparam int ROW_W       = $clog2(ROW_SELECTS);
  localparam int COL_W       = (MAX_WIDTH_BYTES > 1) ? $clog2(MAX_WIDTH_BYTES) : 1;
  localparam int FG_W        = (FOLD_GROUPS > 1) ? $clog2(FOLD_GROUPS) : 1;
  localparam int BANK_DEPTH  = ROWS_PER_LINE * MAX_WIDTH_BYTES;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int STORE_DEPTH = LINES * BANK_DEPTH;
  localparam int LOC_W       = (BANK_AW > ADDR_W) ? BANK_AW : ADDR_W;

  typedef logic [COL_W:0] ew_t;

  // Configuration registers
  logic [WIDTH_W-1:0] width_q;
  logic [TICKS_W-1:0] on_q;
  logic [TICKS_W-1:0] off_q;

  // Sequencer state
  phase_e             phase_q, phase_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [FG_W-1:0]    fold_q, fold_d;
  logic [2:0]         bit_q, bit_d;
  logic [TICKS_W-1:0] dwell_q, dwell_d;
  pins_t              pins_q, pins_d;
  logic               load_d;

  // Pipeline and result registers
  logic                   s1_valid_q;
  stage_t                 s1_q;
  logic                   out_valid_q;
  pins_t                  out_pins_q;
  logic [LINES-1:0]       out_lines_q, lines_d;

  // Blanking sweep
  logic                   clearing_q;
  logic [BANK_AW-1:0]     clear_cnt_q;

  logic                   accept;
  logic                   tick_go;
  logic                   s1_move;
  ew_t                    eff_w;
  ew_t                    col_inc;
  logic [COL_W-1:0]       col_eff;
  logic [FG_W-1:0]        fold_rev;
  logic [ROW_W:0]         row_ext;
  logic [TICKS_W:0]       dwell_inc;
  logic [BANK_AW-1:0]     rd_addr;
  logic                   rd_en;
  logic                   wr_req;
  logic [1:0]             wr_bank;
  logic [LOC_W-1:0]       wr_base;
  logic [LOC_W-1:0]       wr_local;
  logic [PIX_W-1:0]       bank_rdata [LINES];

  // Handshake
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clearing_q && (!s1_valid_q || s1_move);
  assign accept     = in_valid_i && in_ready_o;
  assign tick_go    = accept && (mode_i == MODE_TICK);
  assign wr_req     = accept && (mode_i == MODE_WRITE) && (32'(address_i) < STORE_DEPTH);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RST;
      on_q    <= ON_RST;
      off_q   <= OFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH_BYTES: width_q <= cfg_data_i[WIDTH_W-1:0];
        CFG_ON_TICKS:    on_q    <= cfg_data_i[TICKS_W-1:0];
        CFG_OFF_TICKS:   off_q   <= cfg_data_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp panel width to 1..MAX_WIDTH_BYTES
  always_comb begin
    if (width_q == '0) begin
      eff_w = ew_t'(1);
    end else if (32'(width_q) > MAX_WIDTH_BYTES) begin
      eff_w = ew_t'(MAX_WIDTH_BYTES);
    end else begin
      eff_w = ew_t'(width_q);
    end
  end

  assign col_inc   = ew_t'({1'b0, col_q}) + ew_t'(1);
  assign col_eff   = (ew_t'({1'b0, col_q}) >= eff_w) ? '0 : col_q;
  assign dwell_inc = {1'b0, dwell_q} + {{TICKS_W{1'b0}}, 1'b1};
  assign row_ext   = {1'b0, row_q};

  // Sequencer next state
  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    fold_d  = fold_q;
    bit_d   = bit_q;
    dwell_d = dwell_q;
    unique case (phase_q) inside
      PH_SHIFT_HIGH: begin
        phase_d = PH_SHIFT_LOW;
        bit_d   = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          fold_d = fold_q + FG_W'(1);
          if (fold_q == FG_W'(FOLD_GROUPS - 1)) begin
            fold_d = '0;
            col_d  = col_inc[COL_W-1:0];
            if (col_inc >= eff_w) begin
              col_d   = '0;
              phase_d = PH_ROW_SEL;
            end
          end
        end
      end
      PH_ROW_SEL:    phase_d = PH_LATCH_LOW;
      PH_LATCH_LOW:  phase_d = PH_LATCH_HIGH;
      PH_LATCH_HIGH: begin
        dwell_d = '0;
        phase_d = PH_ON;
      end
      PH_ON, PH_OFF: begin
        dwell_d = dwell_inc[TICKS_W-1:0];
        if ((phase_q == PH_ON) && (dwell_inc >= {1'b0, on_q})) begin
          dwell_d = '0;
          phase_d = PH_OFF;
        end
        // Advance to the next scan row
        if (((phase_q == PH_ON) && (dwell_inc >= {1'b0, on_q}) && (off_q == '0)) ||
            ((phase_q == PH_OFF) && (dwell_inc >= {1'b0, off_q}))) begin
          row_d   = (row_q == ROW_W'(ROW_SELECTS - 1)) ? '0 : row_q + ROW_W'(1);
          col_d   = '0;
          fold_d  = '0;
          bit_d   = '0;
          dwell_d = '0;
          phase_d = PH_SHIFT_LOW;
        end
      end
      default: begin
        col_d   = col_eff;
        phase_d = PH_SHIFT_HIGH;
      end
    endcase
  end

  // Pin levels after a tick
  always_comb begin
    pins_d = pins_q;
    load_d = 1'b0;
    unique case (phase_q)
      PH_SHIFT_HIGH: begin
        pins_d.clk = 1'b1;
        pins_d.en  = 1'b0;
      end
      PH_ROW_SEL: begin
        pins_d.row_a = row_ext[0];
        pins_d.row_b = row_ext[1];
        pins_d.en    = 1'b0;
      end
      PH_LATCH_LOW: begin
        pins_d.stb = 1'b0;
        pins_d.en  = 1'b0;
      end
      PH_LATCH_HIGH: begin
        pins_d.stb = 1'b1;
        pins_d.en  = 1'b0;
      end
      PH_ON:  pins_d.en = 1'b1;
      PH_OFF: pins_d.en = 1'b0;
      default: begin
        pins_d.clk = 1'b0;
        pins_d.en  = 1'b0;
        load_d     = 1'b1;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SHIFT_LOW;
      row_q   <= '0;
      col_q   <= '0;
      fold_q  <= '0;
      bit_q   <= '0;
      dwell_q <= '0;
      pins_q  <= '{clk: 1'b0, row_a: 1'b0, row_b: 1'b0, stb: 1'b1, en: 1'b0};
    end else if (tick_go) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
      fold_q  <= fold_d;
      bit_q   <= bit_d;
      dwell_q <= dwell_d;
      pins_q  <= pins_d;
    end
  end

  // Frame read address: fold groups run from the far end of the line
  assign fold_rev = FG_W'(FOLD_GROUPS - 1) - fold_q;
  assign rd_addr  = BANK_AW'((32'(fold_rev) * ROW_SELECTS + 32'(row_q)) * MAX_WIDTH_BYTES
                             + 32'(col_eff));
  assign rd_en    = tick_go && load_d;

  // Split a write address into bank and local address
  always_comb begin
    wr_bank = '0;
    wr_base = '0;
    for (int k = 1; k < LINES; k++) begin
      if (32'(address_i) >= k * BANK_DEPTH) begin
        wr_bank = 2'(k);
        wr_base = LOC_W'(k * BANK_DEPTH);
      end
    end
  end

  assign wr_local = LOC_W'(address_i) - wr_base;

  // Frame store: one bank per data line
  for (genvar g = 0; g < LINES; g++) begin : g_bank
    logic               bank_we;
    logic [BANK_AW-1:0] bank_waddr;
    logic [PIX_W-1:0]   bank_wdata;

    assign bank_we    = clearing_q || (wr_req && (wr_bank == 2'(g)));
    assign bank_waddr = clearing_q ? clear_cnt_q : wr_local[BANK_AW-1:0];
    assign bank_wdata = clearing_q ? PIX_BLANK : pixel_byte_i;

    lpqsd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (bank_waddr),
      .wdata_i (bank_wdata),
      .re_i    (rd_en),
      .raddr_i (rd_addr),
      .rdata_o (bank_rdata[g])
    );
  end

  // Blank the store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clear_cnt_q <= '0;
    end else if (clearing_q) begin
      clear_cnt_q <= clear_cnt_q + BANK_AW'(1);
      if (clear_cnt_q == BANK_AW'(BANK_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Hold the request while its frame bytes are read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.pins    <= tick_go ? pins_d : pins_q;
      s1_q.load    <= rd_en;
      s1_q.bit_sel <= bit_q;
    end
  end

  // Pick the shown bit, MSB first; otherwise keep the lines
  always_comb begin
    lines_d = out_lines_q;
    if (s1_q.load) begin
      for (int k = 0; k < LINES; k++) begin
        lines_d[k] = bank_rdata[k][~s1_q.bit_sel];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_lines_q <= '0;
    end else begin
      if (s1_move) begin
        out_valid_q <= 1'b1;
        out_lines_q <= lines_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_pins_q <= s1_q.pins;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign shift_clock_o   = out_pins_q.clk;
  assign line_one_o      = out_lines_q[0];
  assign line_two_o      = out_lines_q[1];
  assign line_three_o    = out_lines_q[2];
  assign line_four_o     = out_lines_q[3];
  assign row_sel_a_o     = out_pins_q.row_a;
  assign row_sel_b_o     = out_pins_q.row_b;
  assign latch_strobe_o  = out_pins_q.stb;
  assign output_enable_o = out_pins_q.en;

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpqsd_pkg::*;

  localparam int FOLDS        = ROWS_PER_LINE_DEF / ROW_SELECTS_DEF;
  localparam int STORE_BYTES  = LINES * ROWS_PER_LINE_DEF * MAX_WIDTH_BYTES_DEF;
  localparam int LIMIT_CYCLES = 250000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 13;

  // Index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
  } panel_req_t;

  // data[0] is line one
  typedef struct packed {
    logic       sclk;
    logic [3:0] data;
    logic       row_a;
    logic       row_b;
    logic       stb;
    logic       en;
  } panel_pins_t;

  // DUT ports
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic                  mode_i       = 1'b0;
  logic [ADDR_W-1:0]     address_i    = '0;
  logic [PIX_W-1:0]      pixel_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic                  shift_clock_o;
  logic                  line_one_o;
  logic                  line_two_o;
  logic                  line_three_o;
  logic                  line_four_o;
  logic                  row_sel_a_o;
  logic                  row_sel_b_o;
  logic                  latch_strobe_o;
  logic                  output_enable_o;

  // Panel model state
  logic [PIX_W-1:0]   frame_mem [STORE_BYTES];
  logic [1:0]         p_row;
  logic [2:0]         p_col;
  logic [1:0]         p_group;
  logic [2:0]         p_bit;
  phase_e             p_phase;
  logic [16:0]        p_dwell;
  panel_pins_t        p_pins;
  logic [WIDTH_W-1:0] cfg_width;
  logic [TICKS_W-1:0] cfg_on;
  logic [TICKS_W-1:0] cfg_off;

  // Request and result queues
  panel_req_t  req_queue [$];
  panel_pins_t pin_queue [$];

  // Driver and monitor state
  panel_req_t  tx_req;
  bit          tx_busy   = 1'b0;
  bit          tx_quiet  = 1'b0;
  bit          rx_quiet  = 1'b0;
  int unsigned tx_gap    = 0;
  int unsigned rx_gap    = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  int unsigned hold_at   = 32'hFFFF_FFFF;
  panel_pins_t got_pins;
  panel_pins_t want_pins;
  int unsigned wrong_fields;

  // Counters
  int unsigned reqs_taken   = 0;
  int unsigned ticks_seen   = 0;
  int unsigned writes_seen  = 0;
  int unsigned rows_done    = 0;
  int unsigned checked_cnt  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned settings_cnt = 0;
  int unsigned cycle_cnt    = 0;

  led_panel_quarter_scan_driver_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .address_i       (address_i),
    .pixel_byte_i    (pixel_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .shift_clock_o   (shift_clock_o),
    .line_one_o      (line_one_o),
    .line_two_o      (line_two_o),
    .line_three_o    (line_three_o),
    .line_four_o     (line_four_o),
    .row_sel_a_o     (row_sel_a_o),
    .row_sel_b_o     (row_sel_b_o),
    .latch_strobe_o  (latch_strobe_o),
    .output_enable_o (output_enable_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp the width register to the usable range
  function automatic logic [3:0] active_width();
    if (cfg_width == '0) return 4'd1;
    if (cfg_width > MAX_WIDTH_BYTES_DEF) return 4'(MAX_WIDTH_BYTES_DEF);
    return cfg_width;
  endfunction

  // Put the current bit of each line's byte on the data pins
  function automatic void present_bits();
    int row_off;
    int idx;
    row_off = (FOLDS - 1 - int'(p_group)) * ROW_SELECTS_DEF + int'(p_row);
    for (int k = 0; k < LINES; k++) begin
      idx = (k * ROWS_PER_LINE_DEF + row_off) * MAX_WIDTH_BYTES_DEF + int'(p_col);
      p_pins.data[k] = frame_mem[idx][PIX_W - 1 - int'(p_bit)];
    end
  endfunction

  function automatic void start_next_row();
    p_row   = p_row + 2'd1;
    p_col   = '0;
    p_group = '0;
    p_bit   = '0;
    p_dwell = '0;
    p_phase = PH_SHIFT_LOW;
    rows_done++;
  endfunction

  // One scan tick of the pin sequencer
  function automatic void advance_scan();
    case (p_phase)
      PH_SHIFT_HIGH: begin
        p_pins.sclk = 1'b1;
        p_pins.en   = 1'b0;
        p_phase     = PH_SHIFT_LOW;
        if (p_bit == 3'd7) begin
          p_bit = '0;
          if (p_group == 2'(FOLDS - 1)) begin
            p_group = '0;
            if (({1'b0, p_col} + 4'd1) >= active_width()) begin
              p_col   = '0;
              p_phase = PH_ROW_SEL;
            end else begin
              p_col = p_col + 3'd1;
            end
          end else begin
            p_group = p_group + 2'd1;
          end
        end else begin
          p_bit = p_bit + 3'd1;
        end
      end
      PH_ROW_SEL: begin
        p_pins.row_a = p_row[0];
        p_pins.row_b = p_row[1];
        p_pins.en    = 1'b0;
        p_phase      = PH_LATCH_LOW;
      end
      PH_LATCH_LOW: begin
        p_pins.stb = 1'b0;
        p_pins.en  = 1'b0;
        p_phase    = PH_LATCH_HIGH;
      end
      PH_LATCH_HIGH: begin
        p_pins.stb = 1'b1;
        p_pins.en  = 1'b0;
        p_dwell    = '0;
        p_phase    = PH_ON;
      end
      PH_ON: begin
        p_pins.en = 1'b1;
        p_dwell   = p_dwell + 17'd1;
        if (p_dwell >= {1'b0, cfg_on}) begin
          p_dwell = '0;
          if (cfg_off == '0) start_next_row();
          else p_phase = PH_OFF;
        end
      end
      PH_OFF: begin
        p_pins.en = 1'b0;
        p_dwell   = p_dwell + 17'd1;
        if (p_dwell >= {1'b0, cfg_off}) start_next_row();
      end
      default: begin
        // shift low, also taken for any unused code
        p_pins.sclk = 1'b0;
        p_pins.en   = 1'b0;
        if ({1'b0, p_col} >= active_width()) p_col = '0;
        present_bits();
        p_phase = PH_SHIFT_HIGH;
      end
    endcase
  endfunction

  // Apply one request to the panel model and return the pin levels after it
  function automatic panel_pins_t predict_pins(panel_req_t r);
    if (r.mode == MODE_WRITE) begin
      if (int'(r.addr) < STORE_BYTES) frame_mem[r.addr] = r.pix;
      writes_seen++;
    end else begin
      advance_scan();
      ticks_seen++;
    end
    return p_pins;
  endfunction

  function automatic int unsigned draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_WIDTH_BYTES: cfg_width = val[WIDTH_W-1:0];
      CFG_ON_TICKS:    cfg_on    = val;
      CFG_OFF_TICKS:   cfg_off   = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_panel(input logic [CFG_DATA_W-1:0] w_val,
                           input logic [CFG_DATA_W-1:0] on_val,
                           input logic [CFG_DATA_W-1:0] off_val);
    write_reg(CFG_WIDTH_BYTES, w_val);
    write_reg(CFG_ON_TICKS, on_val);
    write_reg(CFG_OFF_TICKS, off_val);
    settings_cnt++;
  endtask

  task automatic queue_req(input logic mode, input logic [ADDR_W-1:0] a,
                           input logic [PIX_W-1:0] p);
    panel_req_t r;
    r.mode = mode;
    r.addr = a;
    r.pix  = p;
    req_queue.push_back(r);
  endtask

  // Hold until every queued request is taken and every result has come back
  task automatic wait_drained();
    while (req_queue.size() != 0 || tx_busy || pin_queue.size() != 0) @(posedge clk_i);
  endtask

  // Driver: offer queued requests, predict each one as it is accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tx_busy = 1'b0;
      tx_gap  = 0;
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pin_queue.push_back(predict_pins(tx_req));
        tx_busy = 1'b0;
        tx_gap  = draw_gap(tx_quiet);
        reqs_taken <= reqs_taken + 1;
      end
      if (!tx_busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (req_queue.size() != 0) begin
          tx_req  = req_queue.pop_front();
          tx_busy = 1'b1;
          mode_i       <= tx_req.mode;
          address_i    <= tx_req.addr;
          pixel_byte_i <= tx_req.pix;
        end
      end
      in_valid_i <= tx_busy;
    end
  end

  // Monitor: check each result against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_gap = 0;
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_pins = {shift_clock_o, {line_four_o, line_three_o, line_two_o, line_one_o},
                    row_sel_a_o, row_sel_b_o, latch_strobe_o, output_enable_o};
        if (pin_queue.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("tb: result with nothing expected: clk=%b data=%b a=%b b=%b stb=%b en=%b",
                     got_pins.sclk, got_pins.data, got_pins.row_a, got_pins.row_b,
                     got_pins.stb, got_pins.en);
        end else begin
          want_pins = pin_queue.pop_front();
          wrong_fields = 0;
          if (got_pins.sclk  !== want_pins.sclk)  wrong_fields++;
          if (got_pins.data  !== want_pins.data)  wrong_fields++;
          if (got_pins.row_a !== want_pins.row_a) wrong_fields++;
          if (got_pins.row_b !== want_pins.row_b) wrong_fields++;
          if (got_pins.stb   !== want_pins.stb)   wrong_fields++;
          if (got_pins.en    !== want_pins.en)    wrong_fields++;
          if (wrong_fields != 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("tb: result %0d wrong: expected clk=%b data=%b a=%b b=%b stb=%b en=%b",
                       checked_cnt, want_pins.sclk, want_pins.data, want_pins.row_a,
                       want_pins.row_b, want_pins.stb, want_pins.en);
              $display("tb:   got clk=%b data=%b a=%b b=%b stb=%b en=%b",
                       got_pins.sclk, got_pins.data, got_pins.row_a, got_pins.row_b,
                       got_pins.stb, got_pins.en);
            end
          end
        end
        checked_cnt++;
        rx_gap = draw_gap(rx_quiet);
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, started once a set number of requests is in
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && reqs_taken == hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [3:0]  w_nib;
    int unsigned n_items;

    // Model state after reset
    for (int i = 0; i < STORE_BYTES; i++) frame_mem[i] = PIX_BLANK;
    p_row     = '0;
    p_col     = '0;
    p_group   = '0;
    p_bit     = '0;
    p_phase   = PH_SHIFT_LOW;
    p_dwell   = '0;
    p_pins    = '0;
    p_pins.stb = 1'b1;
    cfg_width = WIDTH_RST;
    cfg_on    = ON_RST;
    cfg_off   = OFF_RST;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Write past the register list during the clearing sweep; must change nothing
    write_reg(CFG_UNUSED, 16'hFFFF);

    // Directed: corner bytes, one byte per line in the first shifted row
    queue_req(MODE_WRITE, 9'd0,   8'h00);
    queue_req(MODE_WRITE, 9'd511, 8'h00);
    queue_req(MODE_WRITE, 9'd96,  8'h5A);
    queue_req(MODE_WRITE, 9'd224, 8'hA5);
    queue_req(MODE_WRITE, 9'd352, 8'h0F);
    queue_req(MODE_WRITE, 9'd480, 8'hF0);
    repeat (8) queue_req(MODE_TICK, 9'h1FF, 8'hFF);
    // overwrite a byte while it is being shifted out
    queue_req(MODE_WRITE, 9'd96, 8'hFF);
    repeat (8) queue_req(MODE_TICK, 9'd0, 8'h00);
    wait_drained();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      n_items  = 80;
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      case (p)
        0: begin
          // width zero, no on dwell, no off dwell; no idling either side
          set_panel(16'hFFF0, 16'd0, 16'd0);
          tx_quiet = 1'b1;
          rx_quiet = 1'b1;
        end
        1: begin
          set_panel(16'd1, 16'd1, 16'd1);
          hold_at = reqs_taken + 12;
        end
        2: set_panel(16'h000F, 16'd3, 16'd2);
        3: begin
          // longest dwells; enough ticks to shift out a one-byte row
          set_panel(16'd1, 16'hFFFF, 16'hFFFF);
          n_items = 120;
        end
        4: set_panel(16'd2, 16'd2, 16'd0);
        5: set_panel(16'd8, 16'd1, 16'd1);
        6: set_panel(16'd1, 16'd1, 16'd3);
        default: begin
          w_nib = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 2));
          set_panel({12'($urandom), w_nib}, 16'($urandom_range(0, 3)),
                    16'($urandom_range(0, 4)));
        end
      endcase
      for (int i = 0; i < int'(n_items); i++) begin
        panel_req_t r;
        r.mode = ($urandom_range(0, 3) != 0) ? MODE_TICK : MODE_WRITE;
        r.pix  = PIX_W'($urandom);
        // mostly bytes that the current width shows, sometimes anywhere
        if ($urandom_range(0, 3) != 0)
          r.addr = ADDR_W'($urandom_range(0, 63) * MAX_WIDTH_BYTES_DEF
                           + $urandom_range(0, int'(active_width()) - 1));
        else
          r.addr = ADDR_W'($urandom);
        req_queue.push_back(r);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d requests (%0d ticks, %0d writes), %0d results checked, %0d mismatches",
             reqs_taken, ticks_seen, writes_seen, checked_cnt, mismatch_cnt);
    $display("tb: %0d scan rows completed over %0d register settings, one %0d-cycle hold-off",
             rows_done, settings_cnt, HOLD_CYCLES);
    if (mismatch_cnt == 0 && pin_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
